@@ hdl/xfc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the XOR frame checker: frame constants, config register indexes,
// status codes and the item type that travels from the front to the back.
// No dependencies.
package xfc_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int COUNT_W      = 17;
    localparam int TOTAL_W      = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // header byte positions
    localparam logic [COUNT_W-1:0] POS_MAGIC   = 17'd0;
    localparam logic [COUNT_W-1:0] POS_VERSION = 17'd1;
    localparam logic [COUNT_W-1:0] POS_TYPE    = 17'd2;
    localparam logic [COUNT_W-1:0] POS_LEN_LO  = 17'd3;
    localparam logic [COUNT_W-1:0] POS_LEN_HI  = 17'd4;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEN = 1'b1;

    localparam logic [7:0] MAGIC_RESET   = 8'h00;
    localparam logic [7:0] MIN_LEN_RESET = 8'd6;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_MAGIC = 3'd2,
        ST_SIZE  = 3'd3,
        ST_CSUM  = 3'd4
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    // one classified request: a payload byte or an end of frame report with its check flags
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  frame_type;
        logic [7:0]  version;
        logic [15:0] length;
        logic        too_short;
        logic        bad_magic;
        logic        size_bad;
        logic        csum_bad;
    } frame_item_t;

endpackage

@@ hdl/xor_frame_checker.sv @@
`timescale 1ns / 1ps
// XOR frame checker top level: front end, request queue, back end.
// The result of an accepted byte passes through the request queue and the output register.
// Throughput: one byte per cycle while the queue is not full; the output register and the queue keep
// input acceptance going while a result waits for out_ready, until the queue fills.
// Reset (rst_n low, asynchronous): frame state, queue and output valid clear,
// magic_reg returns to 0 and min_len_reg to 6. Config writes are registered; cfg_ready is tied high.
module xor_frame_checker
    import xfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   kind,
    output logic [7:0]             payload_byte,
    output logic [2:0]             status,
    output logic [7:0]             frame_type,
    output logic [7:0]             version,
    output logic [15:0]            payload_length,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic        q_full;
    logic        q_push;
    frame_item_t q_push_item;
    logic        q_pop;
    logic        q_head_valid;
    frame_item_t q_head_item;

    assign cfg_ready = 1'b1;

    xfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    xfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    xfc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_item      (q_head_item),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .frame_type     (frame_type),
        .version        (version),
        .payload_length (payload_length)
    );

endmodule

@@ hdl/xfc_front.sv @@
`timescale 1ns / 1ps
// Front end of the XOR frame checker: takes bytes, tracks header fields, count
// and running XOR, and classifies each byte into a queued request or nothing.
// Depends on xfc_pkg.
module xfc_front
    import xfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output frame_item_t            q_item
);

    logic [7:0]         magic_reg;
    logic [7:0]         min_len_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         xor_reg, xor_next;
    logic               magic_ok_reg, magic_ok_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         version_reg, version_next;
    logic [15:0]        length_reg, length_next;

    logic               accept;
    logic               forward;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] payload_end;
    logic [TOTAL_W-1:0] expect_total;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        magic_ok_next = magic_ok_reg;
        version_next  = version_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        case (count_reg)
            POS_MAGIC:   magic_ok_next = (data_byte == magic_reg);
            POS_VERSION: version_next  = data_byte;
            POS_TYPE:    type_next     = data_byte;
            POS_LEN_LO:  length_next   = {length_reg[15:8], data_byte};
            POS_LEN_HI:  length_next   = {data_byte, length_reg[7:0]};
            default:     ;
        endcase
        xor_next   = xor_reg ^ data_byte;
        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : COUNT_MAX;

        total        = {1'b0, count_reg} + 1'b1;
        payload_end  = TOTAL_W'(HEADER_BYTES) + {2'b00, length_next};
        expect_total = payload_end + 1'b1;
        forward      = !frame_end && (count_reg >= COUNT_W'(HEADER_BYTES))
                       && ({1'b0, count_reg} < payload_end);
    end

    always_comb
    begin
        q_item = '0;
        if (frame_end)
        begin
            q_item.kind       = KIND_REPORT;
            q_item.frame_type = type_next;
            q_item.version    = version_next;
            q_item.length     = length_next;
            q_item.too_short  = (total < {{(TOTAL_W-8){1'b0}}, min_len_reg});
            q_item.bad_magic  = !magic_ok_next;
            q_item.size_bad   = (total != expect_total);
            q_item.csum_bad   = (data_byte != xor_reg);
        end
        else
        begin
            q_item.kind = KIND_PAYLOAD;
            q_item.data = data_byte;
        end
    end

    assign q_push = accept && (frame_end || forward);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_MIN_LEN: min_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            xor_reg      <= '0;
            magic_ok_reg <= 1'b0;
            type_reg     <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                // drop all frame state for the next frame
                count_reg    <= '0;
                xor_reg      <= '0;
                magic_ok_reg <= 1'b0;
                type_reg     <= '0;
                version_reg  <= '0;
                length_reg   <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                xor_reg      <= xor_next;
                magic_ok_reg <= magic_ok_next;
                type_reg     <= type_next;
                version_reg  <= version_next;
                length_reg   <= length_next;
            end
        end
    end

endmodule

@@ hdl/xfc_queue.sv @@
`timescale 1ns / 1ps
// Short request queue between front and back of the XOR frame checker.
// Depends on xfc_pkg.
module xfc_queue
    import xfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output frame_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    frame_item_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

@@ hdl/xfc_back.sv @@
`timescale 1ns / 1ps
// Back end of the XOR frame checker: resolves check flags into a status code
// and holds the result in the output register. Depends on xfc_pkg.
module xfc_back
    import xfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  frame_item_t head_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [7:0]  frame_type,
    output logic [7:0]  version,
    output logic [15:0] payload_length
);

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  payload_reg;
    status_t     status_reg, status_next;
    logic [7:0]  type_reg;
    logic [7:0]  version_reg;
    logic [15:0] length_reg;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    // first failing check wins
    always_comb
    begin
        if (head_item.kind == KIND_PAYLOAD)
            status_next = ST_OK;
        else if (head_item.too_short)
            status_next = ST_SHORT;
        else if (head_item.bad_magic)
            status_next = ST_MAGIC;
        else if (head_item.size_bad)
            status_next = ST_SIZE;
        else if (head_item.csum_bad)
            status_next = ST_CSUM;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= head_item.kind;
            payload_reg <= head_item.data;
            status_reg  <= status_next;
            type_reg    <= head_item.frame_type;
            version_reg <= head_item.version;
            length_reg  <= head_item.length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = payload_reg;
    assign status         = status_reg;
    assign frame_type     = type_reg;
    assign version        = version_reg;
    assign payload_length = length_reg;

endmodule

@@ tb/xor_frame_checker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for xor_frame_checker: sends byte frames and noise with
// random gaps and stalls, predicts forwarded payload bytes and end-of-frame reports.
// Depends on xfc_pkg and the xor_frame_checker RTL.
module xor_frame_checker_tb
    import xfc_pkg::*;
();

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int PHASE_BYTES      = 50;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        kind_t       kind;
        logic [7:0]  payload;
        status_t     status;
        logic [7:0]  ftype;
        logic [7:0]  ver;
        logic [15:0] len;
    } deframe_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = '0;
    logic                   frame_end = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   kind;
    logic [7:0]             payload_byte;
    logic [2:0]             status;
    logic [7:0]             frame_type;
    logic [7:0]             version;
    logic [15:0]            payload_length;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MAGIC;
    logic [7:0]             cfg_data = '0;

    // predictor copy of the registers and the frame state
    logic [7:0]         magic_cfg = MAGIC_RESET;
    logic [7:0]         min_len_cfg = MIN_LEN_RESET;
    logic [COUNT_W-1:0] byte_cnt = '0;
    logic [7:0]         xor_acc = '0;
    logic               magic_seen = 1'b0;
    logic [7:0]         type_q = '0;
    logic [7:0]         ver_q = '0;
    logic [15:0]        len_q = '0;

    deframe_out_t expected_q[$];
    deframe_out_t want_r;
    logic [7:0]   frame_buf[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           bytes_sent = 0;
    int           burst_left = 0;
    bit           gaps_on = 1'b1;
    int           rx_mode = 0;
    int           rx_left = 0;

    xor_frame_checker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .frame_type     (frame_type),
        .version        (version),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void note_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    // Advance the deframer state by one byte; return 1 when the byte causes a result.
    function automatic bit deframe_predict(input logic [7:0] b, input logic last,
                                           output deframe_out_t r);
        logic [COUNT_W-1:0] pos;
        logic [7:0]         xor_prev;
        int                 total;
        int                 want_total;
        pos      = byte_cnt;
        xor_prev = xor_acc;
        r.kind    = KIND_PAYLOAD;
        r.payload = '0;
        r.status  = ST_OK;
        r.ftype   = '0;
        r.ver     = '0;
        r.len     = '0;
        case (pos)
            POS_MAGIC:   magic_seen = (b == magic_cfg);
            POS_VERSION: ver_q = b;
            POS_TYPE:    type_q = b;
            POS_LEN_LO:  len_q[7:0] = b;
            POS_LEN_HI:  len_q[15:8] = b;
            default:     ;
        endcase
        xor_acc = xor_acc ^ b;
        if (pos != COUNT_MAX)
            byte_cnt = pos + 1'b1;
        if (!last)
        begin
            if (int'(pos) >= HEADER_BYTES && int'(pos) < HEADER_BYTES + int'(len_q))
            begin
                r.payload = b;
                return 1'b1;
            end
            return 1'b0;
        end
        total      = int'(pos) + 1;
        want_total = HEADER_BYTES + int'(len_q) + 1;
        r.kind = KIND_REPORT;
        if (total < int'(min_len_cfg))
            r.status = ST_SHORT;
        else if (!magic_seen)
            r.status = ST_MAGIC;
        else if (total != want_total)
            r.status = ST_SIZE;
        else if (b != xor_prev)
            r.status = ST_CSUM;
        r.ftype = type_q;
        r.ver   = ver_q;
        r.len   = len_q;
        byte_cnt   = '0;
        xor_acc    = '0;
        magic_seen = 1'b0;
        type_q     = '0;
        ver_q      = '0;
        len_q      = '0;
        return 1'b1;
    endfunction

    // Present one byte, hold it until accepted, then maybe open a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        deframe_out_t r;
        int           gap;
        in_valid  <= 1'b1;
        data_byte <= b;
        frame_end <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        if (deframe_predict(b, last, r))
            expected_q.push_back(r);
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic send_buf();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Header and random payload, no checksum yet.
    function automatic void build_frame(input logic [7:0] magic, input int plen);
        frame_buf.delete();
        frame_buf.push_back(magic);
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(plen[7:0]);
        frame_buf.push_back(plen[15:8]);
        repeat (plen) frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void seal_frame();
        logic [7:0] sum;
        sum = '0;
        foreach (frame_buf[i])
            sum ^= frame_buf[i];
        frame_buf.push_back(sum);
    endfunction

    // Drop valid and wait until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAGIC)
            magic_cfg = val;
        else
            min_len_cfg = val;
        @(posedge clk);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                note_error($sformatf("unexpected result kind %0d byte %02h status %0d",
                                     kind, payload_byte, status));
            else
            begin
                want_r = expected_q.pop_front();
                if (kind !== want_r.kind || payload_byte !== want_r.payload ||
                    status !== want_r.status || frame_type !== want_r.ftype ||
                    version !== want_r.ver || payload_length !== want_r.len)
                    note_error($sformatf(
                        "exp k%0d b%02h s%0d t%02h v%02h l%04h, got k%0d b%02h s%0d t%02h v%02h l%04h",
                        want_r.kind, want_r.payload, want_r.status, want_r.ftype,
                        want_r.ver, want_r.len, kind, payload_byte, status,
                        frame_type, version, payload_length));
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 80);
        end
        else
            rx_left--;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= rx_left[1];
        endcase
    end

    task automatic test_basic_frames();
        // good frame, empty payload
        build_frame(magic_cfg, 0);
        seal_frame();
        send_buf();
        // good frame, extreme header and payload bytes
        build_frame(magic_cfg, 2);
        frame_buf[1] = 8'hFF;
        frame_buf[2] = 8'h00;
        frame_buf[5] = 8'hFF;
        frame_buf[6] = 8'h00;
        seal_frame();
        send_buf();
        // single byte frame
        frame_buf = '{8'hFF};
        send_buf();
        // full header only: too short
        build_frame(magic_cfg, 0);
        send_buf();
        // short beats bad magic, partial header
        build_frame(magic_cfg ^ 8'h5A, 0);
        frame_buf = frame_buf[0:2];
        send_buf();
        // bad magic
        build_frame(magic_cfg ^ 8'h81, 0);
        seal_frame();
        send_buf();
        // bad checksum
        build_frame(magic_cfg, 0);
        seal_frame();
        frame_buf[5] = frame_buf[5] ^ 8'h01;
        send_buf();
        // final flag on a payload byte: report only
        build_frame(magic_cfg, 3);
        frame_buf = frame_buf[0:6];
        send_buf();
        // extra bytes with a bad checksum: size wins
        build_frame(magic_cfg, 1);
        frame_buf.push_back(8'h3C);
        frame_buf.push_back(8'hC3);
        seal_frame();
        frame_buf[8] = ~frame_buf[8];
        send_buf();
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MAGIC, 8'hFF);
        write_reg(REG_MIN_LEN, 8'hFF);
        build_frame(magic_cfg, 0);
        seal_frame();
        send_buf();
        build_frame(magic_cfg, 249);
        seal_frame();
        send_buf();
        drain();
        // minimum below a full header
        write_reg(REG_MIN_LEN, 8'h00);
        frame_buf = '{8'hFF};
        send_buf();
        frame_buf = '{8'h00};
        send_buf();
        drain();
        write_reg(REG_MAGIC, 8'h00);
        write_reg(REG_MIN_LEN, 8'd3);
        build_frame(magic_cfg, 0);
        frame_buf = frame_buf[0:3];
        send_buf();
        drain();
    endtask

    task automatic test_random_traffic();
        int sel;
        int plen;
        int keep;
        int phase_end;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_MAGIC, 8'($urandom_range(0, 255)));
            write_reg(REG_MIN_LEN, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(0, 10)));
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                sel  = $urandom_range(0, 10);
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 6);
                build_frame(magic_cfg, plen);
                seal_frame();
                case (sel)
                    6: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
                    7: frame_buf[frame_buf.size() - 1] =
                           frame_buf[frame_buf.size() - 1] ^ 8'($urandom_range(1, 255));
                    8:
                    begin
                        keep = $urandom_range(1, frame_buf.size() - 1);
                        frame_buf = frame_buf[0:keep - 1];
                    end
                    9:
                    begin
                        frame_buf.delete();
                        repeat ($urandom_range(1, 12))
                            frame_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    10:
                    begin
                        void'(frame_buf.pop_back());
                        repeat ($urandom_range(1, 4))
                            frame_buf.push_back(8'($urandom_range(0, 255)));
                        seal_frame();
                    end
                    default: ;
                endcase
                send_buf();
            end
            drain();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frames();
        test_register_extremes();
        test_random_traffic();
        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
